[sv/ccs_pkg.sv]
// Package for the CAN command segmenter: shared types, constants and the
// frame limit helper. Depends on nothing; every other file uses it.

package ccs_pkg;

    // Default payload bytes per CAN frame and the depth of the payload buffer
    localparam int PAYLOAD_PER_FRAME = 7;
    localparam int BUF_DEPTH         = 7;
    localparam int FILL_W            = $clog2(BUF_DEPTH + 1);
    localparam int BUF_IDX_W         = $clog2(BUF_DEPTH);
    localparam int TDATA_OUT_W       = 88;

    // Where the next command byte goes
    typedef enum logic [1:0] {
        POS_ADDR    = 2'd0,
        POS_FUNC    = 2'd1,
        POS_PAYLOAD = 2'd2
    } ccs_pos_t;

    // One command byte as held in the input register
    typedef struct packed {
        logic [7:0] cmd_byte;
        logic       final_byte;
    } ccs_item_t;

    // One finished frame
    typedef struct packed {
        logic [15:0]     frame_id;
        logic [3:0]      byte_count;
        logic [7:0][7:0] data;
        logic            end_of_command;
        logic            short_error;
    } ccs_frame_t;

    // Clamp the payload size to what the buffer can hold
    function automatic int frame_limit(input int payload);
        int lim;
        lim = payload;
        if (lim < 1)
            lim = 1;
        if (lim > BUF_DEPTH)
            lim = BUF_DEPTH;
        return lim;
    endfunction

endpackage

[sv/ccs_in_stage.sv]
// Input register of the CAN command segmenter: holds one command byte.
// Depends on ccs_pkg.

module ccs_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  ccs_pkg::ccs_item_t s_item,
    input  logic              take,
    output logic              item_valid,
    output ccs_pkg::ccs_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    ccs_pkg::ccs_item_t item_reg;

    // Accept while empty or while the held word is being consumed
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Work out the occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load the payload on accept
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
            item_reg <= s_item;
    end

endmodule

[sv/ccs_core.sv]
// Segmenter core: command position tracking, payload buffer and frame
// assembly for one command byte per cycle while take is high. Depends on ccs_pkg.

module ccs_core #(
    parameter int PAYLOAD_PER_FRAME = ccs_pkg::PAYLOAD_PER_FRAME
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  ccs_pkg::ccs_item_t item,
    output logic               emit,
    output ccs_pkg::ccs_frame_t frame
);

    localparam int FrameLimit = ccs_pkg::frame_limit(PAYLOAD_PER_FRAME);
    localparam logic [ccs_pkg::FILL_W-1:0] FILL_LIMIT = ccs_pkg::FILL_W'(FrameLimit);

    ccs_pkg::ccs_pos_t             pos_reg, pos_next;
    logic [7:0]                    addr_reg, addr_next;
    logic [7:0]                    func_reg, func_next;
    logic [ccs_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic [7:0]                    frame_no_reg, frame_no_next;
    logic [7:0]                    buf_reg [ccs_pkg::BUF_DEPTH];
    logic                          wr_en;
    logic [ccs_pkg::FILL_W-1:0]    fill_inc;
    ccs_pkg::ccs_frame_t           payload_frame;

    // Fill never reaches the frame limit between cycles, so this cannot wrap
    assign fill_inc = fill_reg + 1'b1;

    // Assemble the payload frame, including the byte arriving now
    always_comb
    begin
        logic [ccs_pkg::FILL_W-1:0] idx;
        payload_frame                = '0;
        payload_frame.frame_id       = {addr_reg, frame_no_reg};
        payload_frame.byte_count     = {1'b0, fill_inc} + 4'd1;
        payload_frame.data[0]        = func_reg;
        payload_frame.end_of_command = item.final_byte;
        for (int k = 1; k < 8; k++)
        begin
            idx = ccs_pkg::FILL_W'(k - 1);
            if (idx < fill_reg)
                payload_frame.data[k] = buf_reg[idx[ccs_pkg::BUF_IDX_W-1:0]];
            else if (idx == fill_reg)
                payload_frame.data[k] = item.cmd_byte;
            else
                payload_frame.data[k] = 8'd0;
        end
    end

    // Next state and result
    always_comb
    begin
        pos_next      = pos_reg;
        addr_next     = addr_reg;
        func_next     = func_reg;
        fill_next     = fill_reg;
        frame_no_next = frame_no_reg;
        wr_en         = 1'b0;
        emit          = 1'b0;
        frame         = '0;
        if (take)
        begin
            unique case (pos_reg)
                ccs_pkg::POS_ADDR:
                begin
                    addr_next = item.cmd_byte;
                    if (item.final_byte)
                    begin
                        // Command ended on its address: flag and restart
                        emit              = 1'b1;
                        frame.short_error = 1'b1;
                        fill_next         = '0;
                        frame_no_next     = 8'd0;
                    end
                    else
                        pos_next = ccs_pkg::POS_FUNC;
                end
                ccs_pkg::POS_FUNC:
                begin
                    func_next     = item.cmd_byte;
                    fill_next     = '0;
                    frame_no_next = 8'd0;
                    pos_next      = item.final_byte ? ccs_pkg::POS_ADDR
                                                    : ccs_pkg::POS_PAYLOAD;
                end
                default:
                begin
                    wr_en = 1'b1;
                    frame = payload_frame;
                    if (item.final_byte)
                    begin
                        emit          = 1'b1;
                        pos_next      = ccs_pkg::POS_ADDR;
                        fill_next     = '0;
                        frame_no_next = 8'd0;
                    end
                    else if (fill_inc >= FILL_LIMIT)
                    begin
                        emit          = 1'b1;
                        fill_next     = '0;
                        frame_no_next = frame_no_reg + 8'd1;
                    end
                    else
                        fill_next = fill_inc;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= ccs_pkg::POS_ADDR;
            addr_reg     <= 8'd0;
            func_reg     <= 8'd0;
            fill_reg     <= '0;
            frame_no_reg <= 8'd0;
        end
        else
        begin
            pos_reg      <= pos_next;
            addr_reg     <= addr_next;
            func_reg     <= func_next;
            fill_reg     <= fill_next;
            frame_no_reg <= frame_no_next;
        end
    end

    // Store the payload byte at the fill position
    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_reg[fill_reg[ccs_pkg::BUF_IDX_W-1:0]] <= item.cmd_byte;
    end

endmodule

[sv/ccs_out_stage.sv]
// Result register of the CAN command segmenter: holds one frame until taken.
// Depends on ccs_pkg.

module ccs_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ccs_pkg::ccs_frame_t frame_in,
    output logic                space,
    output logic                m_valid,
    input  logic                m_ready,
    output ccs_pkg::ccs_frame_t frame_out
);

    logic                valid_reg;
    logic                valid_next;
    ccs_pkg::ccs_frame_t frame_reg;

    // Room for a new frame when empty or when the held one leaves now
    assign space     = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign frame_out = frame_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the frame until the next one loads
    always_ff @(posedge clk)
    begin
        if (load)
            frame_reg <= frame_in;
    end

endmodule

[sv/can_command_segmenter_unit.sv]
// Top level of the CAN command segmenter: input register, core, result register.
// Depends on ccs_pkg, ccs_in_stage, ccs_core and ccs_out_stage.
//
//  channel | direction | tdata                 | tlast           | tuser
//  s_*     | in        | cmd_byte              | final_byte      | -
//  m_*     | out       | frame_id, count, data | end_of_command  | short_error
//
// One command byte is accepted per cycle while s_tready is high; the core handles it
// while it is held in the input register, and a frame that it completes is loaded
// into the result register and shown on m_*.
// The throughput is set by the combinational core step: a new byte every cycle unless m_tready stalls.
// Reset clears the position, address, function code, fill count and frame number.
// A stall on m_tready fills the result register, then the input register, then
// holds s_tready low; no word is lost or repeated.

module can_command_segmenter_unit #(
    parameter int PAYLOAD_PER_FRAME = ccs_pkg::PAYLOAD_PER_FRAME
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] cmd_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] frame_id, [19:16] byte_count, [27:20] data_0, [35:28] data_1,
    // [43:36] data_2, [51:44] data_3, [59:52] data_4, [67:60] data_5,
    // [75:68] data_6, [83:76] data_7, [87:84] zero
    output logic [ccs_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser   // [0] short_error
);

    localparam int FrameLimit = ccs_pkg::frame_limit(PAYLOAD_PER_FRAME);

    ccs_pkg::ccs_item_t  s_item;
    ccs_pkg::ccs_item_t  item;
    logic                item_valid;
    logic                out_space;
    logic                take;
    logic                emit;
    ccs_pkg::ccs_frame_t core_frame;
    ccs_pkg::ccs_frame_t out_frame;

    assign s_item.cmd_byte   = s_tdata;
    assign s_item.final_byte = s_tlast;

    // Consume the held byte whenever its result has somewhere to go
    assign take = item_valid && out_space;

    ccs_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ccs_core #(
        .PAYLOAD_PER_FRAME (PAYLOAD_PER_FRAME)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .emit  (emit),
        .frame (core_frame)
    );

    ccs_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .frame_in  (core_frame),
        .space     (out_space),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .frame_out (out_frame)
    );

    // Pack the frame, first field lowest
    assign m_tdata = {4'd0,
                      out_frame.data[7], out_frame.data[6], out_frame.data[5],
                      out_frame.data[4], out_frame.data[3], out_frame.data[2],
                      out_frame.data[1], out_frame.data[0],
                      out_frame.byte_count, out_frame.frame_id};
    assign m_tlast = out_frame.end_of_command;
    assign m_tuser = out_frame.short_error;

`ifndef NO_ASSERTIONS
    // A short-command flag carries no frame content
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0 && !m_tlast))
    else $error("short_error word carries frame data");

    // A frame that does not end the command is a full one
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser && !m_tlast) |-> (m_tdata[19:16] == 4'(FrameLimit + 1)))
    else $error("intermediate frame is not full");

    // A payload frame holds between one byte and the frame limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |->
            (m_tdata[19:16] >= 4'd2 && m_tdata[19:16] <= 4'(FrameLimit + 1)))
    else $error("byte_count out of range");

    // A new result only follows a consumed input byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(take))
    else $error("result appeared without a consumed byte");
`endif

endmodule
